// ===== hw/rtl/tga_rle_pkg.sv =====
// shared types and constants of the tga truecolour rle decoder
`timescale 1ns / 1ps
`default_nettype none

package tga_rle_pkg;

    // header layout
    localparam logic [4:0] HDR_POS_TYPE     = 5'd2;
    localparam logic [4:0] HDR_POS_WIDTH_LO = 5'd12;
    localparam logic [4:0] HDR_POS_WIDTH_HI = 5'd13;
    localparam logic [4:0] HDR_POS_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_POS_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_POS_BPP      = 5'd16;
    localparam logic [4:0] HDR_POS_LAST     = 5'd17;

    // image types and pixel sizes
    localparam logic [7:0] TYPE_RAW_TRUE = 8'd2;
    localparam logic [7:0] TYPE_RLE_TRUE = 8'd10;
    localparam logic [7:0] BPP_WITH_ALPHA = 8'd32;

    // packet header fields
    localparam logic [7:0] PKT_COUNT_MASK = 8'h7F;
    localparam logic [7:0] PKT_RUN_FLAG   = 8'h80;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // one input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } item_t;

    // one result item
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [31:0] pixel_argb;
        logic [7:0]  repeat_count;
        logic [31:0] first_index;
        logic        image_done;
    } result_t;

    // handshake between pipeline stages
    typedef struct packed {
        logic valid;
        logic ready;
    } stage_hs_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tga_rle_if.sv =====
// stream interfaces for the byte input and the result output
`timescale 1ns / 1ps
`default_nettype none

interface tga_rle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tga_rle_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [31:0] pixel_argb;
    logic [7:0]  repeat_count;
    logic [31:0] first_index;
    logic        image_done;

    modport source (
        output valid, output result_kind, output image_width, output image_height,
        output pixel_argb, output repeat_count, output first_index, output image_done,
        input ready
    );
    modport sink (
        input valid, input result_kind, input image_width, input image_height,
        input pixel_argb, input repeat_count, input first_index, input image_done,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/tga_rle_in_reg.sv =====
// input register stage holding one accepted byte item
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_in_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                up_valid,
    output      logic                up_ready,
    input  wire tga_rle_pkg::item_t  up_item,
    output      tga_rle_pkg::stage_hs_t down_hs_valid,
    input  wire logic                down_ready,
    output      tga_rle_pkg::item_t  down_item
);

    logic               valid_reg;
    logic               valid_next;
    tga_rle_pkg::item_t item_reg;

    // take a new item when empty or when the held one moves on
    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_valid ? 1'b1 : (valid_reg && !down_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= up_ready ? valid_next : valid_reg;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= up_item;
        end
    end

    assign down_hs_valid.valid = valid_reg;
    assign down_hs_valid.ready = down_ready;
    assign down_item           = item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tga_rle_decode.sv =====
// header parser and pixel decoder state, one item per cycle while fire is high
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_decode (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire tga_rle_pkg::item_t   item,
    output      logic                 res_valid,
    output      tga_rle_pkg::result_t res
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PACKET = 2'd1;
    localparam logic [1:0] PH_PIXEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [1:0]  phase_reg, phase_next, phase_cur;
    logic [4:0]  hpos_reg, hpos_next, hpos_cur;
    logic [7:0]  itype_reg, itype_next, itype_cur;
    logic [15:0] width_reg, width_next, width_cur;
    logic [15:0] height_reg, height_next, height_cur;
    logic        alpha_reg, alpha_next, alpha_cur;
    logic [7:0]  prem_reg, prem_next, prem_cur;
    logic        run_reg, run_next, run_cur;
    logic [1:0]  cpos_reg, cpos_next, cpos_cur;
    logic [31:0] asm_reg, asm_next, asm_cur;
    logic [31:0] pdone_reg, pdone_next, pdone_cur;
    logic [31:0] pleft_reg, pleft_next, pleft_cur;

    logic        sof;
    logic [7:0]  b;
    logic [31:0] total;
    logic [31:0] argb;
    logic [7:0]  count;
    logic [7:0]  raw_count;
    logic [1:0]  last_pos;
    logic        is_rle;

    assign sof = item.start_of_file;
    assign b   = item.data_byte;

    // state as seen by this item: a start of file clears everything
    assign phase_cur  = sof ? PH_HEADER : phase_reg;
    assign hpos_cur   = sof ? 5'd0  : hpos_reg;
    assign itype_cur  = sof ? 8'd0  : itype_reg;
    assign width_cur  = sof ? 16'd0 : width_reg;
    assign height_cur = sof ? 16'd0 : height_reg;
    assign alpha_cur  = sof ? 1'b0  : alpha_reg;
    assign prem_cur   = sof ? 8'd0  : prem_reg;
    assign run_cur    = sof ? 1'b0  : run_reg;
    assign cpos_cur   = sof ? 2'd0  : cpos_reg;
    assign asm_cur    = sof ? 32'd0 : asm_reg;
    assign pdone_cur  = sof ? 32'd0 : pdone_reg;
    assign pleft_cur  = sof ? 32'd0 : pleft_reg;

    assign total     = 32'(width_cur) * 32'(height_cur);
    assign is_rle    = (itype_cur == tga_rle_pkg::TYPE_RLE_TRUE);
    assign last_pos  = alpha_cur ? 2'd3 : 2'd2;
    assign raw_count = (b & tga_rle_pkg::PKT_COUNT_MASK) + 8'd1;

    // colour assembly with this byte placed at its lane
    always_comb
    begin
        argb = asm_cur;
        case (cpos_cur)
            2'd0:    argb[7:0]   = b;
            2'd1:    argb[15:8]  = b;
            2'd2:    argb[23:16] = b;
            default: argb[31:24] = b;
        endcase
    end

    // next state and result
    always_comb
    begin
        phase_next  = phase_cur;
        hpos_next   = hpos_cur;
        itype_next  = itype_cur;
        width_next  = width_cur;
        height_next = height_cur;
        alpha_next  = alpha_cur;
        prem_next   = prem_cur;
        run_next    = run_cur;
        cpos_next   = cpos_cur;
        asm_next    = asm_cur;
        pdone_next  = pdone_cur;
        pleft_next  = pleft_cur;
        count       = 8'd0;

        res_valid        = 1'b0;
        res.result_kind  = tga_rle_pkg::KIND_HEADER;
        res.image_width  = width_cur;
        res.image_height = height_cur;
        res.pixel_argb   = 32'd0;
        res.repeat_count = 8'd0;
        res.first_index  = 32'd0;
        res.image_done   = 1'b0;

        unique case (phase_cur)
            PH_HEADER:
            begin
                hpos_next = hpos_cur + 5'd1;
                case (hpos_cur)
                    tga_rle_pkg::HDR_POS_TYPE:      itype_next = b;
                    tga_rle_pkg::HDR_POS_WIDTH_LO:  width_next = {8'd0, b};
                    tga_rle_pkg::HDR_POS_WIDTH_HI:  width_next = {b, width_cur[7:0]};
                    tga_rle_pkg::HDR_POS_HEIGHT_LO: height_next = {8'd0, b};
                    tga_rle_pkg::HDR_POS_HEIGHT_HI: height_next = {b, height_cur[7:0]};
                    tga_rle_pkg::HDR_POS_BPP:
                        alpha_next = (b == tga_rle_pkg::BPP_WITH_ALPHA);
                    default: ;
                endcase
                // unsupported image type ends the file at once
                if (hpos_cur == tga_rle_pkg::HDR_POS_TYPE
                    && b != tga_rle_pkg::TYPE_RAW_TRUE && b != tga_rle_pkg::TYPE_RLE_TRUE)
                begin
                    hpos_next       = hpos_cur;
                    phase_next      = PH_DONE;
                    res_valid       = 1'b1;
                    res.result_kind = tga_rle_pkg::KIND_ERROR;
                    res.image_done  = 1'b1;
                end
                else if (hpos_cur == tga_rle_pkg::HDR_POS_LAST)
                begin
                    hpos_next  = hpos_cur;
                    pdone_next = 32'd0;
                    pleft_next = total;
                    cpos_next  = 2'd0;
                    asm_next   = 32'd0;
                    prem_next  = 8'd0;
                    run_next   = 1'b0;
                    res_valid  = 1'b1;
                    if (total == 32'd0)
                    begin
                        phase_next     = PH_DONE;
                        res.image_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = is_rle ? PH_PACKET : PH_PIXEL;
                    end
                end
            end

            PH_PACKET:
            begin
                // clamp the packet to the pixels still to come
                if (pleft_cur[31:8] == 24'd0 && pleft_cur[7:0] < raw_count)
                begin
                    prem_next = pleft_cur[7:0];
                end
                else
                begin
                    prem_next = raw_count;
                end
                run_next   = (b & tga_rle_pkg::PKT_RUN_FLAG) != 8'd0;
                cpos_next  = 2'd0;
                asm_next   = 32'd0;
                phase_next = PH_PIXEL;
            end

            PH_PIXEL:
            begin
                if (cpos_cur != last_pos)
                begin
                    cpos_next = cpos_cur + 2'd1;
                    asm_next  = argb;
                end
                else
                begin
                    cpos_next = 2'd0;
                    asm_next  = 32'd0;
                    if (is_rle && run_cur)
                    begin
                        count     = prem_cur;
                        prem_next = 8'd0;
                    end
                    else
                    begin
                        count     = 8'd1;
                        prem_next = (prem_cur != 8'd0) ? prem_cur - 8'd1 : 8'd0;
                    end
                    pdone_next       = pdone_cur + 32'(count);
                    pleft_next       = pleft_cur - 32'(count);
                    res_valid        = 1'b1;
                    res.result_kind  = tga_rle_pkg::KIND_PIXEL;
                    res.pixel_argb   = argb;
                    res.repeat_count = count;
                    res.first_index  = pdone_cur;
                    res.image_done   = (pleft_next == 32'd0);
                    if (pleft_next == 32'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (is_rle && prem_next == 8'd0)
                    begin
                        phase_next = PH_PACKET;
                    end
                end
            end

            default: ;
        endcase
    end

    // state registers, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hpos_reg   <= 5'd0;
            itype_reg  <= 8'd0;
            width_reg  <= 16'd0;
            height_reg <= 16'd0;
            alpha_reg  <= 1'b0;
            prem_reg   <= 8'd0;
            run_reg    <= 1'b0;
            cpos_reg   <= 2'd0;
            asm_reg    <= 32'd0;
            pdone_reg  <= 32'd0;
            pleft_reg  <= 32'd0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            itype_reg  <= itype_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            alpha_reg  <= alpha_next;
            prem_reg   <= prem_next;
            run_reg    <= run_next;
            cpos_reg   <= cpos_next;
            asm_reg    <= asm_next;
            pdone_reg  <= pdone_next;
            pleft_reg  <= pleft_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tga_rle_out_reg.sv =====
// result register feeding the output channel
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire logic                 load_valid,
    input  wire tga_rle_pkg::result_t load_res,
    output      logic                 can_load,
    output      logic                 valid,
    input  wire logic                 ready,
    output      tga_rle_pkg::result_t res
);

    logic                 valid_reg;
    logic                 valid_next;
    tga_rle_pkg::result_t res_reg;

    // free when empty or when the held result is taken this cycle
    assign can_load   = !valid_reg || ready;
    assign valid_next = load ? load_valid : (valid_reg && !ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
        begin
            res_reg <= load_res;
        end
    end

    assign valid = valid_reg;
    assign res   = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tga_rle_pixel_decoder_core.sv =====
// top level of the tga truecolour rle pixel decoder
// usage:
//   stream carries one file byte per item, with start_of_file marking byte
//   zero of a new file. result carries header, pixel run and error items.
//   the 18-byte header gives one header item (or an error item at the type
//   byte for types other than raw or rle truecolour). raw pixels give one
//   item each; rle run packets give one item with a repeat count.
// timing:
//   one byte is taken every cycle while the result channel does not stall. a
//   byte is held in the input register, decoded against the parser state when
//   the result register can take its outcome, and its result, if any, is
//   loaded into the result register. the parser state update is the loop.
// reset:
//   rst_n clears the parser to the start of a header and empties both
//   registers; start_of_file does the same for the parser at any time.
// stall:
//   while result.ready is low a waiting result holds, one more byte can sit
//   in the input register, then stream.ready drops; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder_core (
    input wire logic         clk,
    input wire logic         rst_n,
    tga_rle_in_if.sink       stream,
    tga_rle_out_if.source    result
);

    tga_rle_pkg::item_t     in_item;
    tga_rle_pkg::item_t     held_item;
    tga_rle_pkg::stage_hs_t held_hs;
    tga_rle_pkg::result_t   dec_res;
    tga_rle_pkg::result_t   out_res;
    logic                   dec_valid;
    logic                   can_load;
    logic                   fire;

    assign in_item.data_byte     = stream.data_byte;
    assign in_item.start_of_file = stream.start_of_file;

    tga_rle_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (stream.valid),
        .up_ready      (stream.ready),
        .up_item       (in_item),
        .down_hs_valid (held_hs),
        .down_ready    (can_load),
        .down_item     (held_item)
    );

    // decode a held item whenever the result register can take its outcome
    assign fire = held_hs.valid && held_hs.ready;

    tga_rle_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (held_item),
        .res_valid (dec_valid),
        .res       (dec_res)
    );

    tga_rle_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .load_valid (dec_valid),
        .load_res   (dec_res),
        .can_load   (can_load),
        .valid      (result.valid),
        .ready      (result.ready),
        .res        (out_res)
    );

    assign result.result_kind  = out_res.result_kind;
    assign result.image_width  = out_res.image_width;
    assign result.image_height = out_res.image_height;
    assign result.pixel_argb   = out_res.pixel_argb;
    assign result.repeat_count = out_res.repeat_count;
    assign result.first_index  = out_res.first_index;
    assign result.image_done   = out_res.image_done;

endmodule

`default_nettype wire
